// ===== design/qu8add_pkg.sv =====
package qu8add_pkg;

   // Multiplier precision: default for the top-level parameter
   localparam int unsigned MULT_BITS_DEF = 23;

   // Field and register widths
   localparam int unsigned ELEM_W  = 8;
   localparam int unsigned MULT_W  = 24;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned OWID_W  = 4;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned DATA_W  = 24;

   // Working width of products, rounded terms and their sum
   localparam int unsigned ACC_W = 36;

   // Register indexes
   localparam logic [INDEX_W-1:0] REG_ZERO_A    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_ZERO_B    = 3'd1;
   localparam logic [INDEX_W-1:0] REG_MULT_A    = 3'd2;
   localparam logic [INDEX_W-1:0] REG_SHIFT_A   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_MULT_B    = 3'd4;
   localparam logic [INDEX_W-1:0] REG_SHIFT_B   = 3'd5;
   localparam logic [INDEX_W-1:0] REG_ZERO_OUT  = 3'd6;
   localparam logic [INDEX_W-1:0] REG_OUT_WIDTH = 3'd7;

   // Register reset values
   localparam logic [MULT_W-1:0]  MULT_RST  = 24'd4194304;
   localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd22;
   localparam logic [OWID_W-1:0]  OWID_RST  = 4'd8;

   // Configuration bundle handed to the datapath
   typedef struct packed {
      logic [ELEM_W-1:0]  zero_a;
      logic [ELEM_W-1:0]  zero_b;
      logic [MULT_W-1:0]  mult_a;
      logic [SHIFT_W-1:0] shift_a;
      logic [MULT_W-1:0]  mult_b;
      logic [SHIFT_W-1:0] shift_b;
      logic [ELEM_W-1:0]  zero_out;
      logic [OWID_W-1:0]  out_width;
   } cfg_type;

   // Round half up, then shift right arithmetically (floor); zero shift passes through
   function automatic logic signed [ACC_W-1:0] round_shift(
      input logic signed [ACC_W-1:0] x,
      input logic [SHIFT_W-1:0]      n
   );
      logic signed [ACC_W-1:0] bias;
      logic signed [ACC_W-1:0] t;
      bias = ACC_W'(1) <<< (n - 5'd1);
      t    = x + bias;
      if (n == '0) begin
         return x;
      end
      return t >>> n;
   endfunction

endpackage

// ===== design/qu8add_core.sv =====
module qu8add_core #(
   parameter int unsigned MULT_BITS = qu8add_pkg::MULT_BITS_DEF
) (
   input  qu8add_pkg::cfg_type                 cfg,
   input  logic [qu8add_pkg::ELEM_W-1:0]       elem_a,
   input  logic [qu8add_pkg::ELEM_W-1:0]       elem_b,
   output logic [qu8add_pkg::ELEM_W-1:0]       sum_q
);

   localparam int unsigned ACC_W = qu8add_pkg::ACC_W;
   localparam int unsigned MULT_W = qu8add_pkg::MULT_W;
   localparam int unsigned SHIFT_W = qu8add_pkg::SHIFT_W;
   localparam logic [63:0] MaskFull = (64'd1 << (MULT_BITS + 1)) - 64'd1;
   localparam logic [MULT_W-1:0] MultMask = MaskFull[MULT_W-1:0];

   logic signed [8:0]         da;
   logic signed [8:0]         db;
   logic signed [MULT_W:0]    ma_s;
   logic signed [MULT_W:0]    mb_s;
   logic signed [ACC_W-1:0]   pa;
   logic signed [ACC_W-1:0]   pb;
   logic [SHIFT_W-1:0]        sa;
   logic [SHIFT_W-1:0]        sb;
   logic [SHIFT_W-1:0]        s;
   logic [SHIFT_W-1:0]        na;
   logic [SHIFT_W-1:0]        nb;
   logic [3:0]                w;
   logic [8:0]                top;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   r;

   // Remove zero points
   assign da = $signed({1'b0, elem_a}) - $signed({1'b0, cfg.zero_a});
   assign db = $signed({1'b0, elem_b}) - $signed({1'b0, cfg.zero_b});

   // Scale by the masked multipliers
   assign ma_s = $signed({1'b0, cfg.mult_a & MultMask});
   assign mb_s = $signed({1'b0, cfg.mult_b & MultMask});
   assign pa   = ACC_W'(ma_s) * ACC_W'(da);
   assign pb   = ACC_W'(mb_s) * ACC_W'(db);

   // Shift zero counts as one; common shift is the smaller minus one
   assign sa = (cfg.shift_a == '0) ? 5'd1 : cfg.shift_a;
   assign sb = (cfg.shift_b == '0) ? 5'd1 : cfg.shift_b;
   assign s  = ((sa < sb) ? sa : sb) - 5'd1;
   assign na = sa - s;
   assign nb = sb - s;

   // Align both terms, add, then apply the final rounding shift
   assign sum = qu8add_pkg::round_shift(pa, na) + qu8add_pkg::round_shift(pb, nb);
   assign r   = qu8add_pkg::round_shift(sum, s) + ACC_W'(cfg.zero_out);

   // Clamp to the configured output width
   assign w   = (cfg.out_width == 4'd0) ? 4'd1 :
                ((cfg.out_width > 4'd8) ? 4'd8 : cfg.out_width);
   assign top = (9'd1 << w) - 9'd1;

   always_comb begin
      if (r < 0) begin
         sum_q = '0;
      end else if (r > $signed(ACC_W'(top))) begin
         sum_q = top[7:0];
      end else begin
         sum_q = r[7:0];
      end
   end

endmodule

// ===== design/quantized_uint8_add.sv =====
// Channel   Ports                                  Direction  Moves
// req       req_valid/req_ready, req_elem_a/b      in         one element pair
// rsp       rsp_valid/rsp_ready, rsp_sum_q         out        one quantized sum
// csr       csr_valid/csr_ready, csr_index/wdata   in         one register write
//
// Two register stages: an input register and a result register, with the
// whole requantize/add/clamp datapath between them. One request per cycle unless a
// stalled result holds the flow; rsp_valid rises when the request reaches the result register.
// Synchronous active-high reset clears valids and restores register defaults.
// A stalled result holds the result register; the input register still takes
// a request while it is empty, and holds its request otherwise.
// csr_ready is always high.
module quantized_uint8_add #(
   parameter int unsigned MULT_BITS = qu8add_pkg::MULT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [qu8add_pkg::ELEM_W-1:0]       req_elem_a,
   input  logic [qu8add_pkg::ELEM_W-1:0]       req_elem_b,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [qu8add_pkg::ELEM_W-1:0]       rsp_sum_q,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qu8add_pkg::INDEX_W-1:0]      csr_index,
   input  logic [qu8add_pkg::DATA_W-1:0]       csr_wdata
);

   qu8add_pkg::cfg_type                 cfg_ff;
   logic                                in_valid_ff;
   logic [qu8add_pkg::ELEM_W-1:0]       elem_a_ff;
   logic [qu8add_pkg::ELEM_W-1:0]       elem_b_ff;
   logic                                out_valid_ff;
   logic [qu8add_pkg::ELEM_W-1:0]       sum_q_ff;
   logic [qu8add_pkg::ELEM_W-1:0]       sum_q_in;
   logic                                out_free;
   logic                                advance;

   // Pipeline handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_sum_q = sum_q_ff;
   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zero_a    <= '0;
         cfg_ff.zero_b    <= '0;
         cfg_ff.mult_a    <= qu8add_pkg::MULT_RST;
         cfg_ff.shift_a   <= qu8add_pkg::SHIFT_RST;
         cfg_ff.mult_b    <= qu8add_pkg::MULT_RST;
         cfg_ff.shift_b   <= qu8add_pkg::SHIFT_RST;
         cfg_ff.zero_out  <= '0;
         cfg_ff.out_width <= qu8add_pkg::OWID_RST;
      end else if (csr_valid) begin
         case (csr_index)
            qu8add_pkg::REG_ZERO_A:    cfg_ff.zero_a    <= csr_wdata[7:0];
            qu8add_pkg::REG_ZERO_B:    cfg_ff.zero_b    <= csr_wdata[7:0];
            qu8add_pkg::REG_MULT_A:    cfg_ff.mult_a    <= csr_wdata[23:0];
            qu8add_pkg::REG_SHIFT_A:   cfg_ff.shift_a   <= csr_wdata[4:0];
            qu8add_pkg::REG_MULT_B:    cfg_ff.mult_b    <= csr_wdata[23:0];
            qu8add_pkg::REG_SHIFT_B:   cfg_ff.shift_b   <= csr_wdata[4:0];
            qu8add_pkg::REG_ZERO_OUT:  cfg_ff.zero_out  <= csr_wdata[7:0];
            qu8add_pkg::REG_OUT_WIDTH: cfg_ff.out_width <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         elem_a_ff <= req_elem_a;
         elem_b_ff <= req_elem_b;
      end
   end

   // Requantize and add
   qu8add_core #(
      .MULT_BITS (MULT_BITS)
   ) u_core (
      .cfg    (cfg_ff),
      .elem_a (elem_a_ff),
      .elem_b (elem_b_ff),
      .sum_q  (sum_q_in)
   );

   // Hold or advance the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_q_ff <= sum_q_in;
      end
   end

endmodule

// ===== verif/testbench.sv =====
module testbench;

   localparam int unsigned ELEM_W  = qu8add_pkg::ELEM_W;
   localparam int unsigned INDEX_W = qu8add_pkg::INDEX_W;
   localparam int unsigned DATA_W  = qu8add_pkg::DATA_W;
   localparam int unsigned MULT_W  = qu8add_pkg::MULT_W;
   localparam int unsigned SHIFT_W = qu8add_pkg::SHIFT_W;
   localparam int unsigned OWID_W  = qu8add_pkg::OWID_W;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned RANDOM_PHASES  = 10;
   localparam int unsigned PHASE_ITEMS    = 73;

   typedef struct packed {
      logic [ELEM_W-1:0] elem_a;
      logic [ELEM_W-1:0] elem_b;
   } elem_pair_type;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid  = 1'b0;
   logic                req_ready;
   logic [ELEM_W-1:0]   req_elem_a = '0;
   logic [ELEM_W-1:0]   req_elem_b = '0;
   logic                rsp_valid;
   logic                rsp_ready  = 1'b0;
   logic [ELEM_W-1:0]   rsp_sum_q;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [INDEX_W-1:0]  csr_index  = '0;
   logic [DATA_W-1:0]   csr_wdata  = '0;

   elem_pair_type          pending_pairs[$];
   logic [ELEM_W-1:0]      sum_expected[$];
   qu8add_pkg::cfg_type    model_cfg;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned error_count    = 0;
   int unsigned requests_seen  = 0;
   int unsigned sums_checked   = 0;
   int unsigned settings_used  = 1;

   quantized_uint8_add dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_elem_a (req_elem_a),
      .req_elem_b (req_elem_b),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sum_q  (rsp_sum_q),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Add half of the last kept unit, then floor by an arithmetic shift
   function automatic longint round_floor_shift(input longint x, input int unsigned n);
      if (n == 0) begin
         return x;
      end
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // Requantize both elements, add at the common shift, offset and clamp
   function automatic logic [ELEM_W-1:0] requant_sum(input qu8add_pkg::cfg_type c,
                                                     input logic [ELEM_W-1:0] a,
                                                     input logic [ELEM_W-1:0] b);
      longint      mmask;
      longint      pa;
      longint      pb;
      longint      total;
      longint      r;
      longint      top;
      int unsigned sa;
      int unsigned sb;
      int unsigned s;
      int unsigned w;
      mmask = (longint'(1) << (qu8add_pkg::MULT_BITS_DEF + 1)) - 1;
      sa = (c.shift_a == '0) ? 1 : int'(c.shift_a);
      sb = (c.shift_b == '0) ? 1 : int'(c.shift_b);
      s  = ((sa < sb) ? sa : sb) - 1;
      w  = (c.out_width == '0) ? 1 : ((c.out_width > 4'd8) ? 8 : int'(c.out_width));
      top = (longint'(1) << w) - 1;
      pa = (longint'(c.mult_a) & mmask) * (longint'(a) - longint'(c.zero_a));
      pb = (longint'(c.mult_b) & mmask) * (longint'(b) - longint'(c.zero_b));
      total = round_floor_shift(pa, sa - s) + round_floor_shift(pb, sb - s);
      r = round_floor_shift(total, s) + longint'(c.zero_out);
      if (r < 0) begin
         r = 0;
      end
      if (r > top) begin
         r = top;
      end
      return r[ELEM_W-1:0];
   endfunction

   // Track register writes in the predictor's copy of the configuration
   always @(posedge clock) begin
      if (reset) begin
         model_cfg <= '{zero_a: '0, zero_b: '0,
                        mult_a: qu8add_pkg::MULT_RST, shift_a: qu8add_pkg::SHIFT_RST,
                        mult_b: qu8add_pkg::MULT_RST, shift_b: qu8add_pkg::SHIFT_RST,
                        zero_out: '0, out_width: qu8add_pkg::OWID_RST};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            qu8add_pkg::REG_ZERO_A:    model_cfg.zero_a    <= csr_wdata[ELEM_W-1:0];
            qu8add_pkg::REG_ZERO_B:    model_cfg.zero_b    <= csr_wdata[ELEM_W-1:0];
            qu8add_pkg::REG_MULT_A:    model_cfg.mult_a    <= csr_wdata[MULT_W-1:0];
            qu8add_pkg::REG_SHIFT_A:   model_cfg.shift_a   <= csr_wdata[SHIFT_W-1:0];
            qu8add_pkg::REG_MULT_B:    model_cfg.mult_b    <= csr_wdata[MULT_W-1:0];
            qu8add_pkg::REG_SHIFT_B:   model_cfg.shift_b   <= csr_wdata[SHIFT_W-1:0];
            qu8add_pkg::REG_ZERO_OUT:  model_cfg.zero_out  <= csr_wdata[ELEM_W-1:0];
            qu8add_pkg::REG_OUT_WIDTH: model_cfg.out_width <= csr_wdata[OWID_W-1:0];
            default: ;
         endcase
      end
   end

   // Request driver: predict on acceptance, hold while stalled, load or idle otherwise
   always @(posedge clock) begin
      elem_pair_type next_pair;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sum_expected.push_back(requant_sum(model_cfg, req_elem_a, req_elem_b));
            requests_seen++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_pair = pending_pairs.pop_front();
               req_elem_a <= next_pair.elem_a;
               req_elem_b <= next_pair.elem_b;
               req_valid  <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compare each sum with the oldest prediction, stall at random
   always @(posedge clock) begin
      logic [ELEM_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sum_expected.size() == 0) begin
               $error("sum_q: no result expected, actual %0d", rsp_sum_q);
               error_count++;
            end else begin
               want = sum_expected.pop_front();
               sums_checked++;
               if (rsp_sum_q !== want) begin
                  $error("sum_q: expected %0d, actual %0d", want, rsp_sum_q);
                  error_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run after too many cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[quantized_uint8_add] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one register write and wait for its handshake; caller drops valid
   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   // Write every register, with random junk above each field narrower than the data word
   task automatic load_cfg(input qu8add_pkg::cfg_type c);
      logic [DATA_W-1:0] junk;
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_ZERO_A,    {junk[DATA_W-1:ELEM_W], c.zero_a});
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_ZERO_B,    {junk[DATA_W-1:ELEM_W], c.zero_b});
      write_reg(qu8add_pkg::REG_MULT_A,    c.mult_a);
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_SHIFT_A,   {junk[DATA_W-1:SHIFT_W], c.shift_a});
      write_reg(qu8add_pkg::REG_MULT_B,    c.mult_b);
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_SHIFT_B,   {junk[DATA_W-1:SHIFT_W], c.shift_b});
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_ZERO_OUT,  {junk[DATA_W-1:ELEM_W], c.zero_out});
      junk = DATA_W'($urandom());
      write_reg(qu8add_pkg::REG_OUT_WIDTH, {junk[DATA_W-1:OWID_W], c.out_width});
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Wait until every queued request is accepted and every sum has come back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_pairs.size() != 0 || req_valid || sum_expected.size() != 0);
      @(posedge clock);
   endtask

   task automatic queue_pair(input int unsigned a, input int unsigned b);
      pending_pairs.push_back('{elem_a: ELEM_W'(a), elem_b: ELEM_W'(b)});
   endtask

   // Pick a multiplier and shift: half the time near unit scale, otherwise wild or extreme
   task automatic pick_scale(output logic [MULT_W-1:0] m, output logic [SHIFT_W-1:0] sh);
      case ($urandom_range(3))
         0, 1: begin
            m  = MULT_W'($urandom_range(32'h0080_0000, 32'h0040_0000));
            sh = SHIFT_W'($urandom_range(24, 19));
         end
         2: begin
            m  = MULT_W'($urandom());
            sh = SHIFT_W'($urandom());
         end
         default: begin
            case ($urandom_range(2))
               0: m = '0;
               1: m = MULT_W'(32'h0080_0000);
               default: m = '1;
            endcase
            case ($urandom_range(2))
               0: sh = '0;
               1: sh = SHIFT_W'(1);
               default: sh = '1;
            endcase
         end
      endcase
   endtask

   function automatic logic [ELEM_W-1:0] near_zero(input logic [ELEM_W-1:0] z);
      int v;
      v = int'(z) + $urandom_range(6) - 3;
      if (v < 0) begin
         v = 0;
      end
      if (v > 255) begin
         v = 255;
      end
      return ELEM_W'(v);
   endfunction

   initial begin
      qu8add_pkg::cfg_type cfg;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: unit scales, plain saturating add
      queue_pair(0, 0);
      queue_pair(255, 255);
      queue_pair(1, 0);
      queue_pair(0, 1);
      queue_pair(128, 127);
      queue_pair(255, 0);
      queue_pair(0, 255);
      queue_pair(170, 85);
      wait_drained();

      // Extreme multipliers and shifts; smaller shift of one makes the final shift zero
      load_cfg('{zero_a: 8'd255, zero_b: 8'd0, mult_a: MULT_W'(32'h0080_0000),
                 shift_a: SHIFT_W'(1), mult_b: '1, shift_b: '1, zero_out: 8'd255,
                 out_width: OWID_W'(8)});
      queue_pair(0, 0);
      queue_pair(255, 255);
      queue_pair(0, 255);
      queue_pair(255, 0);
      wait_drained();

      // Zero shifts and zero output width, both taken as one
      load_cfg('{zero_a: 8'd0, zero_b: 8'd0, mult_a: '0, shift_a: '0,
                 mult_b: MULT_W'(32'h0080_0000), shift_b: '0, zero_out: 8'd0,
                 out_width: '0});
      queue_pair(0, 0);
      queue_pair(1, 1);
      queue_pair(255, 255);
      queue_pair(200, 3);
      wait_drained();

      // Output width above eight, full-range multipliers at the largest shift
      load_cfg('{zero_a: 8'd128, zero_b: 8'd128, mult_a: '1, shift_a: '1,
                 mult_b: '1, shift_b: '1, zero_out: 8'd128, out_width: '1});
      queue_pair(0, 0);
      queue_pair(255, 255);
      queue_pair(127, 129);
      queue_pair(129, 128);
      wait_drained();

      // One-bit output at unit scale
      load_cfg('{zero_a: 8'd0, zero_b: 8'd0,
                 mult_a: qu8add_pkg::MULT_RST, shift_a: qu8add_pkg::SHIFT_RST,
                 mult_b: qu8add_pkg::MULT_RST, shift_b: qu8add_pkg::SHIFT_RST,
                 zero_out: 8'd0, out_width: OWID_W'(1)});
      queue_pair(0, 0);
      queue_pair(1, 0);
      queue_pair(0, 1);
      wait_drained();

      // Random settings, cycling through the idle and stall patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cfg.zero_a   = ELEM_W'($urandom());
         cfg.zero_b   = ELEM_W'($urandom());
         cfg.zero_out = ($urandom_range(3) == 0) ? ELEM_W'($urandom_range(1) * 255)
                                                 : ELEM_W'($urandom());
         pick_scale(cfg.mult_a, cfg.shift_a);
         pick_scale(cfg.mult_b, cfg.shift_b);
         cfg.out_width = ($urandom_range(1) == 0) ? OWID_W'(8) : OWID_W'($urandom());
         load_cfg(cfg);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if ($urandom_range(3) == 0) begin
               queue_pair(near_zero(cfg.zero_a), near_zero(cfg.zero_b));
            end else begin
               queue_pair($urandom_range(255), $urandom_range(255));
            end
         end
         wait_drained();
      end

      // Let any stray result show up before the verdict
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sum_expected.size() != 0) begin
         $error("sum_q: %0d expected results never arrived", sum_expected.size());
         error_count++;
      end
      $display("Sent %0d element pairs under %0d register settings, checked %0d sums,",
               requests_seen, settings_used, sums_checked);
      $display("with sender gaps and receiver stalls mixed across phases.");
      if (error_count == 0) begin
         $display("[quantized_uint8_add] OK");
      end else begin
         $display("[quantized_uint8_add] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/qu8add_pkg.sv
design/qu8add_core.sv
design/quantized_uint8_add.sv
verif/testbench.sv
